FILE: src/qprc_pkg.sv
// Shared types and constants of the QUIC probe reply classifier.
`timescale 1ns / 1ps
package qprc_pkg;

  localparam int MAX_PAYLOAD_BYTES = 1472;
  localparam int IDX_W = 11;

  localparam int UDP_HDR_LEN = 8;
  localparam int HDR_LEN_HASH = 27;
  localparam int HELLO_TOTAL = 1200;
  localparam int INCHOATE_LEN = 24;
  localparam int SHORT_LIMIT = HDR_LEN_HASH + (HELLO_TOTAL - INCHOATE_LEN) - UDP_HDR_LEN;

  localparam int CONN_ID_LAST_IDX = 8;
  localparam int FIRST_WORD_END = 12;
  // word ending at byte index i lies inside the list when i + WORD_FIT <= length
  localparam int LIST_HDR = 17;
  localparam int WORD_FIT = LIST_HDR - FIRST_WORD_END + 4;
  localparam int LIST_MIN_LEN = LIST_HDR + 4;
  localparam int VSEEN_MIN_IDX = FIRST_WORD_END + 1;

  localparam logic [7:0] FLAG_VERS = 8'h01;
  localparam logic [7:0] FLAG_RST = 8'h02;
  localparam logic [31:0] ECHO_TAG = {8'h51, 8'h30, 8'h30, 8'h31};
  localparam logic [31:0] NIBBLE_MASK = 32'h0f0f0f0f;
  localparam logic [31:0] RESERVED_PAT = 32'h0a0a0a0a;
  localparam logic [63:0] CONN_ID_RESET = 64'h474E494E4E414353;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_QUIC = 2'd1;
  localparam logic [1:0] CLASS_UDP = 2'd2;

  localparam logic KIND_VERSION = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] udp_length;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] version_word;
    logic [1:0]  class_code;
    logic        success;
    logic        versions_seen;
    logic        reserved_seen;
    logic        reset_seen;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic      word_valid;
    logic      sum_valid;
    out_item_t word_res;
    out_item_t sum_res;
  } push_t;

endpackage

FILE: src/qprc_core.sv
// Per-reply parsing state and the single-pass step that classifies each byte.
`timescale 1ns / 1ps
module qprc_core import qprc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_item_t    item,
  input  logic        cfg_write,
  input  logic [63:0] cfg_data,
  output push_t       push
);

  logic [63:0]      expected_conn_id;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      length_reg, length_reg_next;
  logic [7:0]       flags_reg, flags_reg_next;
  logic [63:0]      conn_id_acc, conn_id_acc_next;
  logic [31:0]      word_acc, word_acc_next;
  logic [1:0]       class_reg, class_reg_next;
  logic             success_reg, success_reg_next;
  logic             echo_reg, echo_reg_next;
  logic             reserved_reg, reserved_reg_next;

  logic [IDX_W-1:0] idx;
  logic [2:0]       lane;
  logic             in_window;
  logic             list_ok;
  logic             word_fits;
  logic             short_udp;
  logic             vseen;
  logic             rseen;
  logic             word_valid;

  always_comb begin
    // start of a reply: clear everything but the length, which is reloaded
    idx               = item.first_byte ? '0 : byte_index;
    length_reg_next   = item.first_byte ? item.udp_length : length_reg;
    flags_reg_next    = item.first_byte ? '0 : flags_reg;
    conn_id_acc_next  = item.first_byte ? '0 : conn_id_acc;
    word_acc_next     = item.first_byte ? '0 : word_acc;
    class_reg_next    = item.first_byte ? CLASS_NONE : class_reg;
    success_reg_next  = item.first_byte ? 1'b0 : success_reg;
    echo_reg_next     = item.first_byte ? 1'b0 : echo_reg;
    reserved_reg_next = item.first_byte ? 1'b0 : reserved_reg;
    byte_index_next   = idx;
    word_valid        = 1'b0;
    lane              = 3'(idx - IDX_W'(1));

    in_window = (length_reg_next > 16'(UDP_HDR_LEN)) &&
                (length_reg_next < 16'(SHORT_LIMIT));
    list_ok   = in_window && ((flags_reg_next & FLAG_VERS) != '0);
    word_fits = ({5'b0, idx} + 16'(WORD_FIT)) <= length_reg_next;

    if (idx < IDX_W'(MAX_PAYLOAD_BYTES)) begin
      if (idx == '0) begin
        flags_reg_next = item.data_byte;
      end else if (idx <= IDX_W'(CONN_ID_LAST_IDX)) begin
        for (int k = 0; k < 8; k++) begin
          if (lane == 3'(k)) begin
            conn_id_acc_next[8*k +: 8] = item.data_byte;
          end
        end
        if (idx == IDX_W'(CONN_ID_LAST_IDX) && length_reg_next > 16'(UDP_HDR_LEN) &&
            conn_id_acc_next == expected_conn_id) begin
          class_reg_next   = CLASS_QUIC;
          success_reg_next = 1'b1;
        end
      end else begin
        word_acc_next = {word_acc_next[23:0], item.data_byte};
        if (idx[1:0] == 2'b00 && list_ok && !echo_reg_next && word_fits) begin
          if (idx == IDX_W'(FIRST_WORD_END) && word_acc_next == ECHO_TAG) begin
            echo_reg_next    = 1'b1;
            class_reg_next   = CLASS_UDP;
            success_reg_next = 1'b0;
          end else begin
            if ((word_acc_next & NIBBLE_MASK) == RESERVED_PAT) begin
              reserved_reg_next = 1'b1;
            end
            word_valid = 1'b1;
          end
        end
      end
      byte_index_next = idx + IDX_W'(1);
    end

    short_udp = length_reg_next <= 16'(UDP_HDR_LEN);
    vseen = list_ok && (length_reg_next >= 16'(LIST_MIN_LEN)) &&
            (byte_index_next >= IDX_W'(VSEEN_MIN_IDX)) && !echo_reg_next;
    rseen = in_window && ((flags_reg_next & FLAG_VERS) == '0) &&
            ((flags_reg_next & FLAG_RST) != '0) && (byte_index_next != '0);

    push.word_valid             = word_valid;
    push.word_res               = '0;
    push.word_res.result_kind   = KIND_VERSION;
    push.word_res.version_word  = word_acc_next;

    push.sum_valid              = item.last_byte;
    push.sum_res.result_kind    = KIND_SUMMARY;
    push.sum_res.version_word   = '0;
    push.sum_res.class_code     = short_udp ? CLASS_UDP : class_reg_next;
    push.sum_res.success        = short_udp ? 1'b0 : success_reg_next;
    push.sum_res.versions_seen  = vseen;
    push.sum_res.reserved_seen  = vseen & reserved_reg_next;
    push.sum_res.reset_seen     = rseen;
    push.sum_res.last_result    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_conn_id <= CONN_ID_RESET;
    end else if (cfg_write) begin
      expected_conn_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      length_reg   <= '0;
      flags_reg    <= '0;
      conn_id_acc  <= '0;
      word_acc     <= '0;
      class_reg    <= CLASS_NONE;
      success_reg  <= 1'b0;
      echo_reg     <= 1'b0;
      reserved_reg <= 1'b0;
    end else if (step) begin
      byte_index   <= byte_index_next;
      length_reg   <= length_reg_next;
      flags_reg    <= flags_reg_next;
      conn_id_acc  <= conn_id_acc_next;
      word_acc     <= word_acc_next;
      class_reg    <= class_reg_next;
      success_reg  <= success_reg_next;
      echo_reg     <= echo_reg_next;
      reserved_reg <= reserved_reg_next;
    end
  end

  ap_index_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(MAX_PAYLOAD_BYTES))
    else $error("byte index ran past the payload limit");

  ap_echo_is_udp: assert property (@(posedge clk) disable iff (rst)
    echo_reg |-> (class_reg == CLASS_UDP && !success_reg))
    else $error("echoed version without udp class");

endmodule

FILE: src/qprc_outq.sv
// Two-entry result queue that takes up to two results per cycle and gives one when not stalled.
`timescale 1ns / 1ps
module qprc_outq import qprc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_en,
  input  push_t     push,
  output logic [1:0] space,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t  q0, q0_next;
  out_item_t  q1, q1_next;
  logic [1:0] count, count_next;
  logic [1:0] count_after;
  logic [1:0] n_push;
  logic       pop;
  out_item_t  first_res;

  always_comb begin
    pop         = (count != 2'd0) && !out_stall;
    count_after = count - {1'b0, pop};
    space       = 2'd2 - count_after;
    n_push      = push_en ? ({1'b0, push.word_valid} + {1'b0, push.sum_valid}) : 2'd0;
    first_res   = push.word_valid ? push.word_res : push.sum_res;

    q0_next = pop ? q1 : q0;
    q1_next = q1;
    case (count_after)
      2'd0: begin
        q0_next = first_res;
        q1_next = push.sum_res;
      end
      2'd1: begin
        q1_next = first_res;
      end
      default: begin
        q1_next = q1;
      end
    endcase
    count_next = count_after + n_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign out_valid = (count != 2'd0);
  assign out_data  = q0;

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    n_push <= space)
    else $error("result queue overflow");

  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue count out of range");

endmodule

FILE: src/quic_probe_reply_classifier.sv
// Top level of the QUIC probe reply classifier: input register, parser step, result queue.
//
//   channel | direction | handshake           | payload
//   in      | in        | in_valid / in_stall  | in_data   (in_item_t)
//   out     | out       | out_valid / out_stall| out_data  (out_item_t)
//   cfg     | in        | cfg_valid / cfg_ready| cfg_data  (expected connection id)
//
// One byte is taken per cycle while in_stall is low; it is held in in_q, and its results in the queue.
// A byte that produces a version word and a summary puts two results in the
// two-entry queue, which drains one per cycle while out_stall is low; that queue sets the stall.
// rst is synchronous; it reloads the default connection id and clears the reply.
// cfg_ready is always high.
`timescale 1ns / 1ps
module quic_probe_reply_classifier import qprc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic       in_valid_q;
  in_item_t   in_q;
  push_t      push;
  logic [1:0] space;
  logic [1:0] need;
  logic       proc;

  assign need     = {1'b0, push.word_valid} + {1'b0, push.sum_valid};
  assign proc     = in_valid_q && (need <= space);
  assign in_stall = in_valid_q && !proc;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  qprc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (proc),
    .item      (in_q),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  qprc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (proc),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ap_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid_q)
    else $error("stall raised with empty input register");

  ap_result_follows: assert property (@(posedge clk) disable iff (rst)
    (proc && need != 2'd0) |=> out_valid)
    else $error("processed request left no result");

endmodule

FILE: tb/sv/qprc_reply_checker.sv
// Checker for the QUIC probe reply classifier: predicts results per request and compares.
`timescale 1ns / 1ps
module qprc_reply_checker import qprc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          results_owed
);

  logic [63:0] probe_id;
  logic [IDX_W-1:0] idx_r;
  logic [15:0] len_r;
  logic [7:0] flags_r;
  logic [63:0] cid_acc;
  logic [31:0] word_r;
  logic [1:0] class_r;
  logic succ_r;
  logic echo_r;
  logic rsv_r;

  out_item_t reply_results[$];
  out_item_t head;
  int fails = 0;
  int owed = 0;

  assign fail_count = fails;
  assign results_owed = owed;

  function automatic logic version_list_on();
    return len_r > UDP_HDR_LEN && len_r < SHORT_LIMIT && (flags_r & FLAG_VERS) != 8'h00;
  endfunction

  function automatic int words_listed();
    return len_r >= LIST_HDR ? (int'(len_r) - LIST_HDR) / 4 : 0;
  endfunction

  task automatic clear_reply();
    idx_r = '0;
    flags_r = '0;
    cid_acc = '0;
    word_r = '0;
    class_r = CLASS_NONE;
    succ_r = 1'b0;
    echo_r = 1'b0;
    rsv_r = 1'b0;
  endtask

  task automatic classify_byte(input in_item_t it);
    int pos;
    int slot;
    out_item_t res;
    logic short_udp;
    logic vseen;
    logic rseen;
    if (it.first_byte) begin
      clear_reply();
      len_r = it.udp_length;
    end
    pos = int'(idx_r);
    if (pos < MAX_PAYLOAD_BYTES) begin
      if (pos == 0) begin
        flags_r = it.data_byte;
      end else if (pos <= CONN_ID_LAST_IDX) begin
        cid_acc = cid_acc | ({56'd0, it.data_byte} << (8 * (pos - 1)));
        if (pos == CONN_ID_LAST_IDX && len_r > UDP_HDR_LEN && cid_acc == probe_id) begin
          class_r = CLASS_QUIC;
          succ_r = 1'b1;
        end
      end else begin
        word_r = {word_r[23:0], it.data_byte};
        if (((pos - 9) % 4) == 3 && version_list_on() && !echo_r) begin
          slot = (pos - 9) / 4;
          if (slot < words_listed()) begin
            if (slot == 0 && word_r == ECHO_TAG) begin
              echo_r = 1'b1;
              class_r = CLASS_UDP;
              succ_r = 1'b0;
            end else begin
              if ((word_r & NIBBLE_MASK) == RESERVED_PAT) rsv_r = 1'b1;
              res = '0;
              res.result_kind = KIND_VERSION;
              res.version_word = word_r;
              reply_results.push_back(res);
            end
          end
        end
      end
      idx_r = idx_r + 1'b1;
    end
    if (it.last_byte) begin
      short_udp = len_r <= UDP_HDR_LEN;
      vseen = version_list_on() && words_listed() > 0 && idx_r >= VSEEN_MIN_IDX && !echo_r;
      rseen = len_r > UDP_HDR_LEN && len_r < SHORT_LIMIT && (flags_r & FLAG_VERS) == 8'h00
              && (flags_r & FLAG_RST) != 8'h00 && idx_r >= 1;
      res = '0;
      res.result_kind = KIND_SUMMARY;
      res.class_code = short_udp ? CLASS_UDP : class_r;
      res.success = short_udp ? 1'b0 : succ_r;
      res.versions_seen = vseen;
      res.reserved_seen = vseen & rsv_r;
      res.reset_seen = rseen;
      res.last_result = 1'b1;
      reply_results.push_back(res);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      probe_id = CONN_ID_RESET;
      len_r = '0;
      clear_reply();
      reply_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          fails++;
        end else begin
          head = reply_results.pop_front();
          check_field("result_kind", 32'(head.result_kind), 32'(out_data.result_kind));
          check_field("version_word", head.version_word, out_data.version_word);
          check_field("class_code", 32'(head.class_code), 32'(out_data.class_code));
          check_field("success", 32'(head.success), 32'(out_data.success));
          check_field("versions_seen", 32'(head.versions_seen),
                      32'(out_data.versions_seen));
          check_field("reserved_seen", 32'(head.reserved_seen),
                      32'(out_data.reserved_seen));
          check_field("reset_seen", 32'(head.reset_seen), 32'(out_data.reset_seen));
          check_field("last_result", 32'(head.last_result), 32'(out_data.last_result));
        end
      end
      if (cfg_valid && cfg_ready) probe_id = cfg_data;
      if (in_valid && !in_stall) classify_byte(in_data);
    end
    owed <= reply_results.size();
  end

endmodule

FILE: tb/sv/tb_quic_probe_reply_classifier.sv
// Testbench top for the QUIC probe reply classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_quic_probe_reply_classifier;
  import qprc_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_BYTES = 330;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  int fail_count;
  int results_owed;
  int bytes_sent = 0;
  int cycle_count = 0;
  bit in_steady = 1'b0;
  logic [63:0] cur_id = CONN_ID_RESET;
  logic [63:0] id_plan[5];

  quic_probe_reply_classifier u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  qprc_reply_checker u_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .results_owed(results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ($urandom & ~NIBBLE_MASK) | RESERVED_PAT;
    if (r == 3) return ECHO_TAG;
    return $urandom;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [15:0] len);
    int gap;
    in_data <= {b, first, last, len};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_reply(input logic [15:0] len, input int nbytes, input logic [7:0] flags,
                            input logic [63:0] cid, input bit echo, input bit open_first,
                            input int extra_last);
    logic [7:0] pl[$];
    logic [31:0] w;
    pl.push_back(flags);
    for (int k = 0; k < 8; k++) pl.push_back(cid[8*k +: 8]);
    while (pl.size() < nbytes) begin
      w = (pl.size() == 9 && echo) ? ECHO_TAG : pick_word();
      for (int k = 3; k >= 0; k--) pl.push_back(w[8*k +: 8]);
    end
    while (pl.size() > nbytes) void'(pl.pop_back());
    for (int i = 0; i < nbytes; i++) begin
      send_byte(pl[i], i == 0 && !open_first, i == nbytes - 1 || i == extra_last, len);
    end
  endtask

  task automatic random_reply();
    int r;
    logic [15:0] len;
    int nbytes;
    logic [7:0] flags;
    logic [63:0] cid;
    bit open_first;
    int extra_last;
    in_steady = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 75) cid = cur_id;
    else if (r < 87) cid = cur_id ^ (64'd1 << $urandom_range(0, 63));
    else cid = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 60) flags = 8'(($urandom_range(0, 255) & ~FLAG_RST) | FLAG_VERS);
    else if (r < 75) flags = 8'(($urandom_range(0, 255) & ~FLAG_VERS) | FLAG_RST);
    else flags = 8'($urandom_range(0, 255));
    open_first = 1'b0;
    extra_last = -1;
    if ($urandom_range(0, 99) < 75) begin
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 200))
                                          : 16'($urandom_range(9, 68));
      nbytes = len - 8;
    end else begin
      r = $urandom_range(0, 3);
      if (r == 0) len = 16'($urandom_range(0, UDP_HDR_LEN));
      else if (r == 1) len = 16'($urandom_range(0, 65535));
      else if (r == 2) len = 16'(SHORT_LIMIT - 1 + $urandom_range(0, 1));
      else len = 16'(LIST_HDR + $urandom_range(0, 8));
      nbytes = $urandom_range(1, 40);
      open_first = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) extra_last = $urandom_range(0, nbytes - 1);
    end
    send_reply(len, nbytes, flags, cid, $urandom_range(0, 9) == 0, open_first, extra_last);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_probe_id(input logic [63:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_id = v;
  endtask

  initial begin
    forever begin
      int hold;
      int n;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
      n = pick_gap(1'b0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_quic_probe_reply_classifier: FAIL");
    $finish;
  end

  initial begin
    int phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'hFF, 1'b0, 1'b1, 16'h0000);
    send_byte(8'h00, 1'b0, 1'b1, 16'hFFFF);
    send_byte(8'h00, 1'b1, 1'b1, 16'h0000);
    send_byte(FLAG_VERS, 1'b1, 1'b1, 16'hFFFF);
    send_byte(FLAG_VERS, 1'b1, 1'b1, 16'(SHORT_LIMIT));
    send_reply(16'd21, 13, FLAG_VERS, cur_id, 1'b1, 1'b0, -1);
    send_reply(16'(SHORT_LIMIT - 1), 2, FLAG_RST, cur_id, 1'b0, 1'b0, -1);

    id_plan[0] = 64'h0;
    id_plan[1] = '1;
    id_plan[2] = {$urandom, $urandom};
    id_plan[3] = CONN_ID_RESET;
    id_plan[4] = {$urandom, $urandom};
    foreach (id_plan[p]) begin
      settle();
      write_probe_id(id_plan[p]);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_reply();
    end

    in_steady = 1'b0;
    send_reply(16'(SHORT_LIMIT - 1), MAX_PAYLOAD_BYTES + 18, FLAG_VERS, cur_id, 1'b0, 1'b0, -1);
    settle();

    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_quic_probe_reply_classifier: PASS");
    end else begin
      $display("tb_quic_probe_reply_classifier: FAIL");
    end
    $finish;
  end

endmodule
